// File: hdl/memory_and_io_register_map_top_macros.svh
// assertion macros for the register map block
`ifndef MEMORY_AND_IO_REGISTER_MAP_TOP_MACROS_SVH
`define MEMORY_AND_IO_REGISTER_MAP_TOP_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define MIOREG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is asserted
`define MIOREG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/mioreg_pkg.sv
package mioreg_pkg;

  localparam int unsigned STORE_BYTES = 65536;
  localparam int unsigned ADDR_W      = $clog2(STORE_BYTES);

  // register and range addresses
  localparam logic [15:0] A_VIDEO_LO      = 16'h4000;  // 0040000
  localparam logic [15:0] A_ROM_LO        = 16'h8000;  // 0100000
  localparam logic [15:0] A_IO_WIN_LO     = 16'hFD70;  // 0176560
  localparam logic [15:0] A_IO_WIN_END    = 16'hFD78;  // 0176570
  localparam logic [15:0] A_KBD_CSR       = 16'hFFB0;  // 0177660
  localparam logic [15:0] A_KBD_CSR_HI    = 16'hFFB1;
  localparam logic [15:0] A_KBD_DATA      = 16'hFFB2;  // 0177662
  localparam logic [15:0] A_SCROLL        = 16'hFFB4;  // 0177664
  localparam logic [15:0] A_SCROLL_HI     = 16'hFFB5;
  localparam logic [15:0] A_TMR_RELOAD    = 16'hFFC6;  // 0177706
  localparam logic [15:0] A_TMR_RELOAD_HI = 16'hFFC7;
  localparam logic [15:0] A_TMR_COUNT     = 16'hFFC8;  // 0177710
  localparam logic [15:0] A_TMR_COUNT_HI  = 16'hFFC9;
  localparam logic [15:0] A_TMR_CTRL      = 16'hFFCA;  // 0177712
  localparam logic [15:0] A_TMR_CTRL_HI   = 16'hFFCB;
  localparam logic [15:0] A_PAR_PORT      = 16'hFFCC;  // 0177714
  localparam logic [15:0] A_PAR_PORT_HI   = 16'hFFCD;
  localparam logic [15:0] A_SYS_PORT      = 16'hFFCE;  // 0177716
  localparam logic [15:0] A_SYS_PORT_HI   = 16'hFFCF;

  localparam logic [15:0] MASK_RESET      = 16'hFFFE;
  localparam logic [15:0] SCROLL_MASK     = 16'h02FF;  // 01377
  localparam logic [15:0] LATCH_KEEP      = 16'hFF0F;
  localparam logic [15:0] LATCH_BITS      = 16'h00F0;
  localparam logic [7:0]  KBD_READY_CLR   = 8'h7F;     // low byte of 0177577
  localparam logic [7:0]  STORE_FILL      = 8'hFF;

  typedef enum logic [1:0] {
    REQ_RD_BYTE = 2'd0,
    REQ_RD_WORD = 2'd1,
    REQ_WR_BYTE = 2'd2,
    REQ_WR_WORD = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    RD_PAIR_LO,
    RD_PAIR_HI,
    RD_TMR_LO,
    RD_TMR_HI,
    RD_KBD
  } rd_sel_e;

  typedef enum logic [2:0] {
    WR_CLEAR,
    WR_LO,
    WR_HI,
    WR_TMR_LO,
    WR_TMR_HI,
    WR_KBD
  } wr_sel_e;

  typedef struct packed {
    logic    load;
    logic    cap_lo;
    logic    cap_hi;
    rd_sel_e rd_sel;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    clr_step;
    logic    finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic do_write;
    logic wr_word;
    logic do_copy;
    logic do_clr7;
    logic clr_last;
  } dp_status_t;

endpackage

// File: hdl/mioreg_store.sv
module mioreg_store (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [mioreg_pkg::ADDR_W-1:0] waddr_i,
  input  logic [7:0]                   wdata_i,
  input  logic [mioreg_pkg::ADDR_W-1:0] raddr_i,
  output logic [7:0]                   rdata_o
);
  import mioreg_pkg::*;

  logic [7:0] mem [STORE_BYTES];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/mioreg_ctrl.sv
module mioreg_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  mioreg_pkg::dp_status_t status_i,
  output mioreg_pkg::ctrl_cmd_t  cmd_o
);
  import mioreg_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_A,
    S_RD_B,
    S_RD_C,
    S_CP_A,
    S_CP_B,
    S_CP_C,
    S_KB_A,
    S_KB_B,
    S_WR_LO,
    S_WR_HI,
    S_FIN
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '{load: 1'b0, cap_lo: 1'b0, cap_hi: 1'b0, rd_sel: RD_PAIR_LO,
                wr_en: 1'b0, wr_sel: WR_CLEAR, clr_step: 1'b0, finish: 1'b0};
    case (state_q)
      S_CLEAR: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.wr_sel   = WR_CLEAR;
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_RD_A;
        end
      end
      S_RD_A: begin
        cmd_o.rd_sel = RD_PAIR_LO;
        state_d      = S_RD_B;
      end
      S_RD_B: begin
        cmd_o.rd_sel = RD_PAIR_HI;
        cmd_o.cap_lo = 1'b1;
        state_d      = S_RD_C;
      end
      S_RD_C: begin
        cmd_o.cap_hi = 1'b1;
        if (status_i.do_copy) begin
          state_d = S_CP_A;
        end else if (status_i.do_clr7) begin
          state_d = S_KB_A;
        end else if (status_i.do_write) begin
          state_d = S_WR_LO;
        end else begin
          state_d = S_FIN;
        end
      end
      S_CP_A: begin
        cmd_o.rd_sel = RD_TMR_LO;
        state_d      = S_CP_B;
      end
      S_CP_B: begin
        cmd_o.rd_sel = RD_TMR_HI;
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_TMR_LO;
        state_d      = S_CP_C;
      end
      S_CP_C: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_TMR_HI;
        state_d      = S_WR_LO;
      end
      S_KB_A: begin
        cmd_o.rd_sel = RD_KBD;
        state_d      = S_KB_B;
      end
      S_KB_B: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_KBD;
        state_d      = S_FIN;
      end
      S_WR_LO: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_LO;
        state_d      = status_i.wr_word ? S_WR_HI : S_FIN;
      end
      S_WR_HI: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_HI;
        state_d      = S_FIN;
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule

// File: hdl/mioreg_dp.sv
module mioreg_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mioreg_pkg::ctrl_cmd_t  cmd_i,
  output mioreg_pkg::dp_status_t status_o,
  input  logic [1:0]             req_type_i,
  input  logic [15:0]            address_i,
  input  logic [15:0]            write_data_i,
  input  logic [15:0]            system_port_in_i,
  input  logic                   cfg_we_i,
  input  logic [15:0]            cfg_data_i,
  output logic                   done_o,
  output logic [15:0]            read_data_o,
  output logic                   access_error_o,
  output logic [15:0]            port_out_value_o,
  output logic                   speaker_event_o,
  output logic                   monitor_update_o,
  output logic                   scroll_update_o,
  output logic [7:0]             scroll_delta_o,
  output logic                   timer_run_o,
  output logic                   timer_update_o,
  output logic                   video_write_o
);
  import mioreg_pkg::*;

  // request and configuration
  req_e        req_q;
  logic [15:0] addr_q;
  logic [15:0] wdata_q;
  logic [15:0] port_in_q;
  logic [15:0] mask_q;

  // fetched pair, clear sweep, port latch
  logic [7:0]        lo_q, hi_q;
  logic [ADDR_W-1:0] clr_addr_q;
  logic [15:0]       latch_q, latch_d;

  // results
  logic        done_q;
  logic [15:0] rdata_q;
  logic        err_q, spk_q, mon_q, scr_q, trun_q, tupd_q, vid_q;
  logic [7:0]  delta_q;

  // store port
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata, mem_rdata;

  // decode
  logic        is_wr, is_byte_wr, is_word_wr, prot, ok_wr, scroll_wr, spk;
  logic [15:0] pair_addr;
  logic [7:0]  b;
  logic [7:0]  wr_lo_val, wr_hi_val;
  logic [15:0] rd_val, prev_s, now_s;
  logic        mon, scr;
  logic [7:0]  delta;

  always_comb begin
    is_byte_wr = (req_q == REQ_WR_BYTE);
    is_word_wr = (req_q == REQ_WR_WORD);
    is_wr      = is_byte_wr || is_word_wr;
    b          = wdata_q[7:0];
    prot = ((addr_q >= A_ROM_LO) && (addr_q < A_IO_WIN_LO)) ||
           ((addr_q >= A_IO_WIN_END) && (addr_q < A_KBD_CSR)) ||
           ((addr_q > A_SCROLL_HI) && (addr_q < A_TMR_RELOAD)) ||
           (addr_q > A_SYS_PORT_HI);
    ok_wr      = is_wr && !prot;
    scroll_wr  = ok_wr && ((is_byte_wr && ((addr_q == A_SCROLL) || (addr_q == A_SCROLL_HI))) ||
                           (is_word_wr && (addr_q == A_SCROLL)));
    spk        = ok_wr && (addr_q == A_SYS_PORT);
    pair_addr  = (is_byte_wr && (addr_q == A_SCROLL_HI)) ? A_SCROLL : addr_q;

    status_o.do_copy  = ok_wr &&
                        ((is_byte_wr && ((addr_q == A_TMR_CTRL) || (addr_q == A_TMR_CTRL_HI))) ||
                         (is_word_wr && (addr_q == A_TMR_CTRL)));
    status_o.do_clr7  = !is_wr && (addr_q == A_KBD_DATA);
    status_o.do_write = ok_wr && !(addr_q == A_SYS_PORT) &&
                        !(is_byte_wr && (addr_q == A_SYS_PORT_HI)) &&
                        !(is_word_wr && (addr_q == A_TMR_COUNT));
    status_o.wr_word  = is_word_wr;
    status_o.clr_last = (clr_addr_q == ADDR_W'(STORE_BYTES - 1));

    // bytes to store
    wr_lo_val = is_byte_wr ? b : wdata_q[7:0];
    wr_hi_val = wdata_q[15:8];
    if (is_byte_wr) begin
      case (addr_q)
        A_KBD_CSR:     wr_lo_val = (lo_q & 8'h80) | (b & 8'h40);
        A_KBD_CSR_HI:  wr_lo_val = 8'h00;
        A_SCROLL_HI:   wr_lo_val = b & 8'h02;
        A_TMR_CTRL_HI: wr_lo_val = 8'hFF;
        default:       wr_lo_val = b;
      endcase
    end else begin
      case (addr_q)
        A_KBD_CSR: begin
          wr_lo_val = (lo_q & 8'h80) | (wdata_q[7:0] & 8'h40);
          wr_hi_val = 8'h00;
        end
        A_SCROLL: begin
          wr_lo_val = wdata_q[7:0] & SCROLL_MASK[7:0];
          wr_hi_val = wdata_q[15:8] & SCROLL_MASK[15:8];
        end
        A_TMR_CTRL: begin
          wr_hi_val = 8'hFF;
        end
        default: begin
          wr_hi_val = wdata_q[15:8];
        end
      endcase
    end

    // scroll change detection
    prev_s = {hi_q, lo_q} & SCROLL_MASK;
    if (is_word_wr) begin
      now_s = wdata_q & SCROLL_MASK;
    end else if (addr_q == A_SCROLL) begin
      now_s = {hi_q, b} & SCROLL_MASK;
    end else begin
      now_s = {wr_lo_val, lo_q} & SCROLL_MASK;
    end
    mon   = scroll_wr && (now_s != prev_s) && (now_s[9] != prev_s[9]);
    scr   = scroll_wr && (now_s != prev_s) && (now_s[9] == prev_s[9]);
    delta = scr ? (now_s[7:0] - prev_s[7:0]) : 8'h00;

    // port latch
    latch_d = latch_q;
    if (spk) begin
      latch_d = (latch_q & LATCH_KEEP) | ({8'h00, b} & LATCH_BITS);
    end else if (ok_wr && is_byte_wr && (addr_q == A_SYS_PORT_HI)) begin
      latch_d = latch_q & LATCH_BITS;
    end

    // read value
    rd_val = 16'h0000;
    if (req_q == REQ_RD_BYTE) begin
      case (addr_q)
        A_KBD_CSR:   rd_val = {8'h00, lo_q & 8'hC0};
        A_KBD_DATA:  rd_val = {8'h00, lo_q & 8'h7F};
        A_SCROLL_HI: rd_val = {8'h00, lo_q & 8'h02};
        A_SYS_PORT:  rd_val = {8'h00, port_in_q[7:0]};
        A_SYS_PORT_HI, A_PAR_PORT, A_PAR_PORT_HI: rd_val = 16'h0000;
        default:     rd_val = {8'h00, lo_q};
      endcase
    end else if (req_q == REQ_RD_WORD) begin
      case (addr_q)
        A_KBD_CSR:  rd_val = {hi_q, lo_q} & 16'h00C0;
        A_KBD_DATA: rd_val = {hi_q, lo_q} & 16'h007F;
        A_SCROLL:   rd_val = {hi_q, lo_q} & SCROLL_MASK;
        A_TMR_CTRL: rd_val = {8'hFF, lo_q};
        A_SYS_PORT: rd_val = port_in_q;
        A_PAR_PORT: rd_val = 16'h0000;
        default:    rd_val = {hi_q, lo_q};
      endcase
    end
  end

  // store addressing
  always_comb begin
    case (cmd_i.rd_sel)
      RD_PAIR_LO: mem_raddr = pair_addr;
      RD_PAIR_HI: mem_raddr = pair_addr + 16'd1;
      RD_TMR_LO:  mem_raddr = A_TMR_RELOAD;
      RD_TMR_HI:  mem_raddr = A_TMR_RELOAD_HI;
      RD_KBD:     mem_raddr = A_KBD_CSR;
      default:    mem_raddr = pair_addr;
    endcase
    mem_we = cmd_i.wr_en;
    case (cmd_i.wr_sel)
      WR_CLEAR: begin
        mem_waddr = clr_addr_q;
        mem_wdata = STORE_FILL;
      end
      WR_LO: begin
        mem_waddr = addr_q;
        mem_wdata = wr_lo_val;
      end
      WR_HI: begin
        mem_waddr = addr_q + 16'd1;
        mem_wdata = wr_hi_val;
      end
      WR_TMR_LO: begin
        mem_waddr = A_TMR_COUNT;
        mem_wdata = mem_rdata;
      end
      WR_TMR_HI: begin
        mem_waddr = A_TMR_COUNT_HI;
        mem_wdata = mem_rdata;
      end
      WR_KBD: begin
        mem_waddr = A_KBD_CSR;
        mem_wdata = mem_rdata & KBD_READY_CLR;
      end
      default: begin
        mem_waddr = clr_addr_q;
        mem_wdata = STORE_FILL;
      end
    endcase
  end

  mioreg_store u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q     <= MASK_RESET;
      clr_addr_q <= '0;
      latch_q    <= 16'h0000;
      done_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mask_q <= cfg_data_i;
      end
      if (cmd_i.clr_step) begin
        clr_addr_q <= clr_addr_q + ADDR_W'(1);
      end
      if (cmd_i.finish) begin
        latch_q <= latch_d;
      end
      done_q <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q     <= req_e'(req_type_i);
      addr_q    <= req_type_i[0] ? (address_i & mask_q) : address_i;
      wdata_q   <= write_data_i;
      port_in_q <= system_port_in_i;
    end
    if (cmd_i.cap_lo) begin
      lo_q <= mem_rdata;
    end
    if (cmd_i.cap_hi) begin
      hi_q <= mem_rdata;
    end
    if (cmd_i.finish) begin
      rdata_q <= rd_val;
      err_q   <= is_wr && prot;
      spk_q   <= spk;
      mon_q   <= mon;
      scr_q   <= scr;
      delta_q <= delta;
      trun_q  <= status_o.do_copy && wr_lo_val[4];
      tupd_q  <= status_o.do_copy;
      vid_q   <= ok_wr && (addr_q >= A_VIDEO_LO) && (addr_q < A_ROM_LO);
    end
  end

  assign done_o           = done_q;
  assign read_data_o      = rdata_q;
  assign access_error_o   = err_q;
  assign port_out_value_o = latch_q;
  assign speaker_event_o  = spk_q;
  assign monitor_update_o = mon_q;
  assign scroll_update_o  = scr_q;
  assign scroll_delta_o   = delta_q;
  assign timer_run_o      = trun_q;
  assign timer_update_o   = tupd_q;
  assign video_write_o    = vid_q;

endmodule

// File: hdl/memory_and_io_register_map_top.sv
// requests are taken one at a time: start is accepted only while busy is low, and busy stays
// high until the result strobe; the store has a single write port and a single registered read port
// reset: a clearing pass fills all 65536 bytes with 0xff, one byte per cycle, busy held high
// throughout; config writes taken throughout; results cannot be stalled by the receiver
module memory_and_io_register_map_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [15:0] address_i,
  input  logic [15:0] write_data_i,
  input  logic [15:0] system_port_in_i,
  // word address mask write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  // result strobe and fields
  output logic        done_o,
  output logic [15:0] read_data_o,
  output logic        access_error_o,
  output logic [15:0] port_out_value_o,
  output logic        speaker_event_o,
  output logic        monitor_update_o,
  output logic        scroll_update_o,
  output logic [7:0]  scroll_delta_o,
  output logic        timer_run_o,
  output logic        timer_update_o,
  output logic        video_write_o
);
  import mioreg_pkg::*;

  `include "memory_and_io_register_map_top_macros.svh"

  // command and status between sequencer and datapath
  ctrl_cmd_t  cmd;
  dp_status_t status;

  // mask register is always writable, it only matters at request load
  assign cfg_ready_o = 1'b1;

  // sequencer: clearing pass, pair fetch, timer copy, ready-bit clear, stores, finish
  mioreg_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // datapath: request capture, register decode, byte store, port latch, result registers
  mioreg_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .req_type_i       (req_type_i),
    .address_i        (address_i),
    .write_data_i     (write_data_i),
    .system_port_in_i (system_port_in_i),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .done_o           (done_o),
    .read_data_o      (read_data_o),
    .access_error_o   (access_error_o),
    .port_out_value_o (port_out_value_o),
    .speaker_event_o  (speaker_event_o),
    .monitor_update_o (monitor_update_o),
    .scroll_update_o  (scroll_update_o),
    .scroll_delta_o   (scroll_delta_o),
    .timer_run_o      (timer_run_o),
    .timer_update_o   (timer_update_o),
    .video_write_o    (video_write_o)
  );

  // an accepted request keeps the block busy until its result
  `MIOREG_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy, "request not held")
  // the strobe comes only once the sequencer is back to idle
  `MIOREG_ASSERT_NOW(a_done_idle, clk_i, rst_ni, done_o, !busy, "result while busy")
  // a rejected write raises no event
  `MIOREG_ASSERT_NOW(a_err_quiet, clk_i, rst_ni, done_o && access_error_o, !(speaker_event_o || monitor_update_o || scroll_update_o || timer_update_o || video_write_o), "event on rejected write")
  // mode flip and offset change never reported together
  `MIOREG_ASSERT_NOW(a_scroll_excl, clk_i, rst_ni, done_o, !(monitor_update_o && scroll_update_o), "mode flip and scroll both set")

endmodule
